>>> design/vls_pkg.sv
// ----------------------------------------------------------------------------
// vls_pkg
// Types, constants and register indexes shared by the vertex shading pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package vls_pkg;

  localparam logic [15:0] ONE_Q15 = 16'h8000;

  typedef enum logic [2:0] {
    CFG_LIGHT_X    = 3'd0,
    CFG_LIGHT_Y    = 3'd1,
    CFG_LIGHT_Z    = 3'd2,
    CFG_AMBIENT    = 3'd3,
    CFG_GAIN       = 3'd4,
    CFG_MAT_RG     = 3'd5,
    CFG_MAT_BA     = 3'd6,
    CFG_UNUSED     = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic               has_normal;
    logic               has_color;
    logic [15:0]        color_r;
    logic [15:0]        color_g;
    logic [15:0]        color_b;
    logic [15:0]        color_a;
  } in_t;

  typedef struct packed {
    logic [15:0] shaded_r;
    logic [15:0] shaded_g;
    logic [15:0] shaded_b;
    logic [15:0] shaded_a;
    logic [15:0] light_factor;
  } out_t;

  typedef struct packed {
    logic signed [15:0] light_x;
    logic signed [15:0] light_y;
    logic signed [15:0] light_z;
    logic [15:0]        ambient_level;
    logic [15:0]        diffuse_gain;
    logic [31:0]        material_red_green;
    logic [31:0]        material_blue_alpha;
  } cfg_t;

  // base color and the "lighting is 1.0" flag ride along the whole pipe
  typedef struct packed {
    logic [15:0] r;
    logic [15:0] g;
    logic [15:0] b;
    logic [15:0] a;
    logic        unity;
  } side_t;

  typedef struct packed {
    logic        vld;
    side_t       side;
    logic [31:0] s;
    logic [31:0] d;
  } sq_in_t;

  typedef struct packed {
    logic        vld;
    side_t       side;
    logic [31:0] s;
    logic [31:0] d;
    logic [32:0] rem;
    logic [30:0] root;
  } sq_stage_t;

  typedef struct packed {
    logic        vld;
    side_t       side;
    logic [31:0] d;
    logic [30:0] r;
  } dv_in_t;

  typedef struct packed {
    logic        vld;
    side_t       side;
    logic        sat;
    logic [47:0] rem;
    logic [30:0] r;
    logic [14:0] q;
  } dv_stage_t;

  typedef struct packed {
    logic        vld;
    side_t       side;
    logic [15:0] diffuse;
  } fin_in_t;

endpackage
`default_nettype wire

>>> design/vls_front.sv
// ----------------------------------------------------------------------------
// vls_front
// Base color select, dot product and squared length of the normal.
// ----------------------------------------------------------------------------
`default_nettype none
module vls_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          acc,
  input  vls_pkg::in_t       din,
  input  vls_pkg::cfg_t      cfg,
  output vls_pkg::sq_in_t    dout
);

  logic                 vld_a_r;
  vls_pkg::side_t       side_a_r;
  logic signed [31:0]   px_r, py_r, pz_r, qx_r, qy_r, qz_r;
  vls_pkg::side_t       side_nxt;

  logic                 vld_b_r;
  vls_pkg::side_t       side_b_r;
  vls_pkg::side_t       side_b_nxt;
  logic [31:0]          s_b_r, d_b_r;
  logic signed [33:0]   s_sum, d_sum;

  always_comb begin
    side_nxt.unity = !din.has_normal;
    if (din.has_color) begin
      side_nxt.r = din.color_r;
      side_nxt.g = din.color_g;
      side_nxt.b = din.color_b;
      side_nxt.a = din.color_a;
    end else begin
      side_nxt.r = cfg.material_red_green[15:0];
      side_nxt.g = cfg.material_red_green[31:16];
      side_nxt.b = cfg.material_blue_alpha[15:0];
      side_nxt.a = cfg.material_blue_alpha[31:16];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else begin
      vld_a_r <= acc;
      vld_b_r <= vld_a_r;
    end
  end

  always_ff @(posedge clk) begin
    side_a_r <= side_nxt;
    px_r     <= din.normal_x * cfg.light_x;
    py_r     <= din.normal_y * cfg.light_y;
    pz_r     <= din.normal_z * cfg.light_z;
    qx_r     <= din.normal_x * din.normal_x;
    qy_r     <= din.normal_y * din.normal_y;
    qz_r     <= din.normal_z * din.normal_z;
  end

  assign d_sum = 34'(px_r) + 34'(py_r) + 34'(pz_r);
  assign s_sum = 34'(qx_r) + 34'(qy_r) + 34'(qz_r);

  always_comb begin
    side_b_nxt       = side_a_r;
    side_b_nxt.unity = side_a_r.unity || (s_sum == 34'sd0);
  end

  always_ff @(posedge clk) begin
    side_b_r <= side_b_nxt;
    s_b_r    <= s_sum[31:0];
    // drop a non-positive dot product to zero: diffuse is clamped there
    d_b_r    <= (d_sum > 34'sd0) ? d_sum[31:0] : 32'd0;
  end

  assign dout.vld  = vld_b_r;
  assign dout.side = side_b_r;
  assign dout.s    = s_b_r;
  assign dout.d    = d_b_r;

endmodule
`default_nettype wire

>>> design/vls_sqrt.sv
// ----------------------------------------------------------------------------
// vls_sqrt
// Pipelined digit-by-digit square root of s * 2^30, one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none
module vls_sqrt (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  vls_pkg::sq_in_t    din,
  output vls_pkg::dv_in_t    dout
);

  vls_pkg::sq_stage_t stg_r [0:30];

  genvar k;
  generate
    for (k = 0; k < 31; k++) begin : g_stage
      localparam int I = 30 - k;
      vls_pkg::sq_stage_t cur;
      logic [1:0]         pair;
      logic [34:0]        acc;
      logic [34:0]        trial;
      logic               take;

      if (k == 0) begin : g_first
        assign cur.vld  = din.vld;
        assign cur.side = din.side;
        assign cur.s    = din.s;
        assign cur.d    = din.d;
        assign cur.rem  = 33'd0;
        assign cur.root = 31'd0;
      end else begin : g_next
        assign cur = stg_r[k-1];
      end

      // the low thirty bits of the radicand are zero
      if (I >= 15) begin : g_pair
        assign pair = cur.s[2*I-29 -: 2];
      end else begin : g_zero
        assign pair = 2'b00;
      end

      assign acc   = {cur.rem, pair};
      assign trial = {2'b00, cur.root, 2'b01};
      assign take  = (acc >= trial);

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          stg_r[k].vld <= 1'b0;
        end else begin
          stg_r[k].vld <= cur.vld;
        end
      end

      always_ff @(posedge clk) begin
        stg_r[k].side <= cur.side;
        stg_r[k].s    <= cur.s;
        stg_r[k].d    <= cur.d;
        stg_r[k].rem  <= take ? 33'(acc - trial) : acc[32:0];
        stg_r[k].root <= {cur.root[29:0], take};
      end
    end
  endgenerate

  assign dout.vld  = stg_r[30].vld;
  assign dout.side = stg_r[30].side;
  assign dout.d    = stg_r[30].d;
  assign dout.r    = stg_r[30].root;

endmodule
`default_nettype wire

>>> design/vls_div.sv
// ----------------------------------------------------------------------------
// vls_div
// Pipelined restoring division d * 2^16 / r, saturated at 1.0 in Q1.15.
// ----------------------------------------------------------------------------
`default_nettype none
module vls_div (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  vls_pkg::dv_in_t    din,
  output vls_pkg::fin_in_t   dout
);

  vls_pkg::dv_stage_t ent_r;
  vls_pkg::dv_stage_t stg_r [0:14];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.vld <= 1'b0;
    end else begin
      ent_r.vld <= din.vld;
    end
  end

  // quotient reaches 1.0 exactly when 2d >= r; otherwise it fits 15 bits
  always_ff @(posedge clk) begin
    ent_r.side <= din.side;
    ent_r.sat  <= ({din.d, 1'b0} >= {2'b00, din.r});
    ent_r.rem  <= {din.d, 16'd0};
    ent_r.r    <= din.r;
    ent_r.q    <= 15'd0;
  end

  genvar k;
  generate
    for (k = 0; k < 15; k++) begin : g_stage
      localparam int J = 14 - k;
      vls_pkg::dv_stage_t cur;
      logic [47:0]        cmp;
      logic               take;
      logic [14:0]        q_n;

      if (k == 0) begin : g_first
        assign cur = ent_r;
      end else begin : g_next
        assign cur = stg_r[k-1];
      end

      assign cmp  = {17'd0, cur.r} << J;
      assign take = (cur.rem >= cmp);

      always_comb begin
        q_n    = cur.q;
        q_n[J] = take;
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          stg_r[k].vld <= 1'b0;
        end else begin
          stg_r[k].vld <= cur.vld;
        end
      end

      always_ff @(posedge clk) begin
        stg_r[k].side <= cur.side;
        stg_r[k].sat  <= cur.sat;
        stg_r[k].rem  <= take ? (cur.rem - cmp) : cur.rem;
        stg_r[k].r    <= cur.r;
        stg_r[k].q    <= q_n;
      end
    end
  endgenerate

  assign dout.vld     = stg_r[14].vld;
  assign dout.side    = stg_r[14].side;
  assign dout.diffuse = stg_r[14].sat ? vls_pkg::ONE_Q15 : {1'b0, stg_r[14].q};

endmodule
`default_nettype wire

>>> design/vls_finish.sv
// ----------------------------------------------------------------------------
// vls_finish
// Gain, ambient add and color scaling, each step behind its own register.
// ----------------------------------------------------------------------------
`default_nettype none
module vls_finish (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  vls_pkg::fin_in_t   din,
  input  vls_pkg::cfg_t      cfg,
  output logic               out_vld,
  output vls_pkg::out_t      out_dat
);

  logic           vld1_r, vld2_r, vld3_r, vld4_r;
  vls_pkg::side_t side1_r, side2_r;
  logic [31:0]    gp1_r;
  logic [15:0]    light2_r, light3_r, a3_r;
  logic [17:0]    lsum;
  logic [31:0]    pr3_r, pg3_r, pb3_r;
  vls_pkg::out_t  dat4_r;

  function automatic logic [15:0] sat_q15(input logic [16:0] v);
    sat_q15 = (v > {1'b0, vls_pkg::ONE_Q15}) ? vls_pkg::ONE_Q15 : v[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
    end else begin
      vld1_r <= din.vld;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
      vld4_r <= vld3_r;
    end
  end

  assign lsum = {2'b00, cfg.ambient_level} + {1'b0, gp1_r[31:15]};

  always_ff @(posedge clk) begin
    side1_r  <= din.side;
    gp1_r    <= cfg.diffuse_gain * din.diffuse;
    side2_r  <= side1_r;
    if (side1_r.unity || (lsum > {2'b00, vls_pkg::ONE_Q15})) begin
      light2_r <= vls_pkg::ONE_Q15;
    end else begin
      light2_r <= lsum[15:0];
    end
    pr3_r    <= side2_r.r * light2_r;
    pg3_r    <= side2_r.g * light2_r;
    pb3_r    <= side2_r.b * light2_r;
    a3_r     <= sat_q15({1'b0, side2_r.a});
    light3_r <= light2_r;
    dat4_r.shaded_r     <= sat_q15(pr3_r[31:15]);
    dat4_r.shaded_g     <= sat_q15(pg3_r[31:15]);
    dat4_r.shaded_b     <= sat_q15(pb3_r[31:15]);
    dat4_r.shaded_a     <= a3_r;
    dat4_r.light_factor <= light3_r;
  end

  assign out_vld = vld4_r;
  assign out_dat = dat4_r;

endmodule
`default_nettype wire

>>> design/vertex_lambert_shading.sv
// ----------------------------------------------------------------------------
// vertex_lambert_shading
// Lambert diffuse plus ambient shading of one vertex per item.
// ----------------------------------------------------------------------------
// One vertex is taken in every clock (busy is always low) and its shaded
// color leaves on out_valid for one cycle; the receiver cannot stall.
// The pipeline holds the square root of the normal length (31 stages, one
// root bit each) and the division by it (16 stages), plus two front stages
// for the dot products and four for gain and color scaling.
// Configuration writes take effect at once and belong between bursts.
`default_nettype none
module vertex_lambert_shading (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  vls_pkg::in_t     in_data,
  output logic             out_valid,
  output vls_pkg::out_t    out_data,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata
);

  vls_pkg::cfg_t    cfg_r;
  vls_pkg::sq_in_t  sq_in;
  vls_pkg::dv_in_t  dv_in;
  vls_pkg::fin_in_t fin_in;
  logic             acc;

  assign busy = 1'b0;
  assign acc  = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.light_x             <= 16'sd5749;
      cfg_r.light_y             <= 16'sd13961;
      cfg_r.light_z             <= -16'sd6570;
      cfg_r.ambient_level       <= 16'd12452;
      cfg_r.diffuse_gain        <= 16'd20316;
      cfg_r.material_red_green  <= 32'h63D75C29;
      cfg_r.material_blue_alpha <= 32'h80006E14;
    end else if (cfg_we) begin
      unique case (vls_pkg::cfg_idx_t'(cfg_index))
        vls_pkg::CFG_LIGHT_X: cfg_r.light_x             <= cfg_wdata[15:0];
        vls_pkg::CFG_LIGHT_Y: cfg_r.light_y             <= cfg_wdata[15:0];
        vls_pkg::CFG_LIGHT_Z: cfg_r.light_z             <= cfg_wdata[15:0];
        vls_pkg::CFG_AMBIENT: cfg_r.ambient_level       <= cfg_wdata[15:0];
        vls_pkg::CFG_GAIN:    cfg_r.diffuse_gain        <= cfg_wdata[15:0];
        vls_pkg::CFG_MAT_RG:  cfg_r.material_red_green  <= cfg_wdata;
        vls_pkg::CFG_MAT_BA:  cfg_r.material_blue_alpha <= cfg_wdata;
        default: ;
      endcase
    end
  end

  vls_front u_front (
    .clk  (clk),
    .rst_n(rst_n),
    .acc  (acc),
    .din  (in_data),
    .cfg  (cfg_r),
    .dout (sq_in)
  );

  vls_sqrt u_sqrt (
    .clk  (clk),
    .rst_n(rst_n),
    .din  (sq_in),
    .dout (dv_in)
  );

  vls_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .din  (dv_in),
    .dout (fin_in)
  );

  vls_finish u_finish (
    .clk    (clk),
    .rst_n  (rst_n),
    .din    (fin_in),
    .cfg    (cfg_r),
    .out_vld(out_valid),
    .out_dat(out_data)
  );

  a_light_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.light_factor <= vls_pkg::ONE_Q15)
    else $error("light factor above 1.0");

  a_color_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.shaded_r <= vls_pkg::ONE_Q15) &&
                  (out_data.shaded_g <= vls_pkg::ONE_Q15) &&
                  (out_data.shaded_b <= vls_pkg::ONE_Q15))
    else $error("shaded color not saturated");

  a_unity_light: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_in.vld && fin_in.side.unity) |=> ##3 (out_valid &&
      out_data.light_factor == vls_pkg::ONE_Q15))
    else $error("missing normal did not give unit lighting");

endmodule
`default_nettype wire
